/* rtl/mcbq_pkg.sv */
// ----------------------------------------------------------------------------
// mcbq_pkg
// Shared types, constants and saturating arithmetic for the multichannel
// Q30 biquad.
// ----------------------------------------------------------------------------
package mcbq_pkg;

    localparam int CH_W        = 5;
    localparam int DATA_W      = 32;
    localparam int PROD_W      = 2 * DATA_W;
    localparam int FRAC_W      = 30;
    localparam int ENABLE_BITS = 21;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    localparam logic signed [DATA_W-1:0] COEF_B0_RESET = 32'sh4000_0000;
    localparam logic [ENABLE_BITS-1:0]   ENABLE_RESET  = 21'h1F_FFFF;
    localparam logic signed [DATA_W-1:0] SAT_MAX       = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] SAT_MIN       = 32'sh8000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COEF_B0     = 3'd0,
        REG_COEF_B1     = 3'd1,
        REG_COEF_B2     = 3'd2,
        REG_COEF_A1     = 3'd3,
        REG_COEF_A2     = 3'd4,
        REG_CHAN_ENABLE = 3'd5
    } t_reg_index;

    typedef struct packed {
        logic [CH_W-1:0]          channel;
        logic signed [DATA_W-1:0] sample_in;
    } t_in_item;

    typedef struct packed {
        logic [CH_W-1:0]          channel_out;
        logic signed [DATA_W-1:0] sample_out;
    } t_out_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] b0;
        logic signed [DATA_W-1:0] b1;
        logic signed [DATA_W-1:0] b2;
        logic signed [DATA_W-1:0] a1;
        logic signed [DATA_W-1:0] a2;
    } t_coefs;

    // Classified request as it waits between front and back
    typedef struct packed {
        logic [CH_W-1:0]          channel;
        logic signed [DATA_W-1:0] sample;
        logic                     in_range;
        logic                     enabled;
    } t_q_entry;

    // One channel's delay line as stored
    typedef struct packed {
        logic signed [DATA_W-1:0] x1;
        logic signed [DATA_W-1:0] x2;
        logic signed [DATA_W-1:0] y1;
        logic signed [DATA_W-1:0] y2;
    } t_line;

    // Request context carried down the arithmetic pipeline
    typedef struct packed {
        logic [CH_W-1:0]          channel;
        logic                     in_range;
        logic                     enabled;
        logic signed [DATA_W-1:0] x0;
        logic signed [DATA_W-1:0] x1;
        logic signed [DATA_W-1:0] y1;
    } t_ctx;

    // Arithmetic shift right by the fraction width, then clamp to 32 bits
    function automatic logic signed [DATA_W-1:0] sat_prod(
        input logic signed [PROD_W-1:0] p
    );
        logic [2:0] top;
        top = p[PROD_W-1:PROD_W-3];
        if (top == 3'b000 || top == 3'b111) begin
            return p[FRAC_W+DATA_W-1:FRAC_W];
        end else if (p[PROD_W-1]) begin
            return SAT_MIN;
        end else begin
            return SAT_MAX;
        end
    endfunction

    function automatic logic signed [DATA_W-1:0] sat_addsub(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b,
        input logic                     sub
    );
        logic signed [DATA_W:0] s;
        if (sub) begin
            s = {a[DATA_W-1], a} - {b[DATA_W-1], b};
        end else begin
            s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
        end
        if (s[DATA_W] != s[DATA_W-1]) begin
            return s[DATA_W] ? SAT_MIN : SAT_MAX;
        end
        return s[DATA_W-1:0];
    endfunction

endpackage

/* rtl/mcbq_front.sv */
// ----------------------------------------------------------------------------
// mcbq_front
// Accepts input requests, tags them with range and enable status and holds
// them in a short queue for the arithmetic back end.
// ----------------------------------------------------------------------------
module mcbq_front #(
    parameter int CHANNELS = 21
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  mcbq_pkg::t_in_item                   i_in_item,
    input  logic [mcbq_pkg::ENABLE_BITS-1:0]     i_enable,
    output logic                                 o_q_valid,
    output mcbq_pkg::t_q_entry                   o_q_entry,
    input  logic                                 i_q_pop
);
    import mcbq_pkg::*;

    localparam logic [7:0] CHAN_LIMIT = 8'(CHANNELS);

    t_q_entry            r_queue [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;
    logic [QCNT_W-1:0]   n_count;
    logic                push;
    logic                pop;
    logic [31:0]         enable_ext;
    t_q_entry            entry;

    assign o_in_stall = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign push       = i_in_valid && !o_in_stall;
    assign pop        = i_q_pop && (r_count != '0);

    // Channels with no enable bit read as disabled
    assign enable_ext = 32'(i_enable);

    always_comb begin
        entry          = '0;
        entry.channel  = i_in_item.channel;
        entry.sample   = i_in_item.sample_in;
        entry.in_range = ({3'b000, i_in_item.channel} < CHAN_LIMIT);
        entry.enabled  = entry.in_range && enable_ext[i_in_item.channel];
    end

    always_comb begin
        n_count = r_count;
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wr_ptr] <= entry;
        end
    end

    assign o_q_valid = (r_count != '0);
    assign o_q_entry = r_queue[r_rd_ptr];

endmodule

/* rtl/mcbq_back.sv */
// ----------------------------------------------------------------------------
// mcbq_back
// Per-channel delay line memory and the six-stage biquad datapath (read,
// multiply, scale, three saturating accumulates), then a final accumulate
// with write-back into the delay line and the output register.
// ----------------------------------------------------------------------------
module mcbq_back #(
    parameter int CHANNELS = 21
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_clear,
    input  mcbq_pkg::t_coefs     i_coefs,
    input  logic                 i_q_valid,
    input  mcbq_pkg::t_q_entry   i_q_entry,
    output logic                 o_q_pop,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output mcbq_pkg::t_out_item  o_out_item
);
    import mcbq_pkg::*;

    localparam int ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int EXT_W  = (ADDR_W > CH_W) ? ADDR_W : CH_W;

    function automatic logic [ADDR_W-1:0] ch_addr(input logic [CH_W-1:0] ch);
        logic [EXT_W-1:0] ext;
        ext = EXT_W'(ch);
        return ext[ADDR_W-1:0];
    endfunction

    // Delay line storage
    t_line                   r_mem [CHANNELS];
    logic [CHANNELS-1:0]     r_line_valid;

    // Stage 1: memory read data
    logic                    r_s1_vld;
    t_q_entry                r_s1_entry;
    logic                    r_s1_lv;
    t_line                   r_rd_data;
    t_line                   line;

    // Stage 2: raw products
    logic                    r_s2_vld;
    t_ctx                    r_s2_ctx;
    logic signed [PROD_W-1:0] r_s2_prod [5];
    logic signed [PROD_W-1:0] n_prod [5];

    // Stage 3: scaled products
    logic                    r_s3_vld;
    t_ctx                    r_s3_ctx;
    logic signed [DATA_W-1:0] r_s3_q [5];

    // Stages 4 to 6: running sum
    logic                    r_s4_vld;
    t_ctx                    r_s4_ctx;
    logic signed [DATA_W-1:0] r_s4_acc;
    logic signed [DATA_W-1:0] r_s4_q2;
    logic signed [DATA_W-1:0] r_s4_q3;
    logic signed [DATA_W-1:0] r_s4_q4;

    logic                    r_s5_vld;
    t_ctx                    r_s5_ctx;
    logic signed [DATA_W-1:0] r_s5_acc;
    logic signed [DATA_W-1:0] r_s5_q3;
    logic signed [DATA_W-1:0] r_s5_q4;

    logic                    r_s6_vld;
    t_ctx                    r_s6_ctx;
    logic signed [DATA_W-1:0] r_s6_acc;
    logic signed [DATA_W-1:0] r_s6_q4;

    logic                    r_out_vld;
    t_out_item               r_out_item;

    logic                    adv;
    logic                    hazard;
    logic                    issue;
    logic                    wr_en;
    logic signed [DATA_W-1:0] y;
    t_ctx                    s1_ctx;

    // The whole pipeline moves together; it holds when the result waits
    assign adv = !r_out_vld || !i_out_stall;

    // Hold a request while an earlier one for the same channel is in flight
    always_comb begin
        hazard = 1'b0;
        if (r_s1_vld && r_s1_entry.channel == i_q_entry.channel) hazard = 1'b1;
        if (r_s2_vld && r_s2_ctx.channel == i_q_entry.channel) hazard = 1'b1;
        if (r_s3_vld && r_s3_ctx.channel == i_q_entry.channel) hazard = 1'b1;
        if (r_s4_vld && r_s4_ctx.channel == i_q_entry.channel) hazard = 1'b1;
        if (r_s5_vld && r_s5_ctx.channel == i_q_entry.channel) hazard = 1'b1;
        if (r_s6_vld && r_s6_ctx.channel == i_q_entry.channel) hazard = 1'b1;
    end

    assign issue   = i_q_valid && adv && !hazard;
    assign o_q_pop = issue;

    // Lines never written since reset or a coefficient change read as zero
    assign line = r_s1_lv ? r_rd_data : '0;

    always_comb begin
        s1_ctx          = '0;
        s1_ctx.channel  = r_s1_entry.channel;
        s1_ctx.in_range = r_s1_entry.in_range;
        s1_ctx.enabled  = r_s1_entry.enabled;
        s1_ctx.x0       = r_s1_entry.sample;
        s1_ctx.x1       = line.x1;
        s1_ctx.y1       = line.y1;
    end

    always_comb begin
        n_prod[0] = i_coefs.b0 * r_s1_entry.sample;
        n_prod[1] = i_coefs.b1 * line.x1;
        n_prod[2] = i_coefs.b2 * line.x2;
        n_prod[3] = i_coefs.a1 * line.y1;
        n_prod[4] = i_coefs.a2 * line.y2;
    end

    assign y     = sat_addsub(r_s6_acc, r_s6_q4, 1'b1);
    assign wr_en = adv && r_s6_vld && r_s6_ctx.in_range;

    // Memory read and write ports
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rd_data <= r_mem[ch_addr(i_q_entry.channel)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[ch_addr(r_s6_ctx.channel)] <= '{
                x1: r_s6_ctx.x0,
                x2: r_s6_ctx.x1,
                y1: y,
                y2: r_s6_ctx.y1
            };
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_valid <= '0;
            r_s1_vld     <= 1'b0;
            r_s2_vld     <= 1'b0;
            r_s3_vld     <= 1'b0;
            r_s4_vld     <= 1'b0;
            r_s5_vld     <= 1'b0;
            r_s6_vld     <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            if (i_clear) begin
                r_line_valid <= '0;
            end else if (wr_en) begin
                r_line_valid[ch_addr(r_s6_ctx.channel)] <= 1'b1;
            end
            if (adv) begin
                r_s1_vld  <= issue;
                r_s2_vld  <= r_s1_vld;
                r_s3_vld  <= r_s2_vld;
                r_s4_vld  <= r_s3_vld;
                r_s5_vld  <= r_s4_vld;
                r_s6_vld  <= r_s5_vld;
                r_out_vld <= r_s6_vld;
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_s1_entry <= i_q_entry;
            r_s1_lv    <= i_q_entry.in_range
                          && r_line_valid[ch_addr(i_q_entry.channel)];
        end
        if (adv) begin
            r_s2_ctx <= s1_ctx;
            for (int k = 0; k < 5; k++) begin
                r_s2_prod[k] <= n_prod[k];
            end

            r_s3_ctx <= r_s2_ctx;
            for (int k = 0; k < 5; k++) begin
                r_s3_q[k] <= sat_prod(r_s2_prod[k]);
            end

            r_s4_ctx <= r_s3_ctx;
            r_s4_acc <= sat_addsub(r_s3_q[0], r_s3_q[1], 1'b0);
            r_s4_q2  <= r_s3_q[2];
            r_s4_q3  <= r_s3_q[3];
            r_s4_q4  <= r_s3_q[4];

            r_s5_ctx <= r_s4_ctx;
            r_s5_acc <= sat_addsub(r_s4_acc, r_s4_q2, 1'b0);
            r_s5_q3  <= r_s4_q3;
            r_s5_q4  <= r_s4_q4;

            r_s6_ctx <= r_s5_ctx;
            r_s6_acc <= sat_addsub(r_s5_acc, r_s5_q3, 1'b1);
            r_s6_q4  <= r_s5_q4;

            r_out_item.channel_out <= r_s6_ctx.channel;
            r_out_item.sample_out  <= r_s6_ctx.enabled ? y : '0;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out_item;

endmodule

/* rtl/multichannel_biquad_q30_highpass_unit.sv */
// A request passes the input queue, datapath stages and output register.
// Throughput: one request per cycle while the output is not stalled and
// neighboring requests use different channels; a request for a channel
// still in the six-stage datapath waits for its write-back first.
// Reset: synchronous, active low; clears queue, pipeline and all delay lines,
// and loads the coefficient and enable register defaults.
// ----------------------------------------------------------------------------
// multichannel_biquad_q30_highpass_unit
// Multichannel Direct Form 1 biquad with shared Q30 coefficients, per-channel
// delay lines and per-channel output enable.
// ----------------------------------------------------------------------------
module multichannel_biquad_q30_highpass_unit #(
    parameter int CHANNELS = 21
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  mcbq_pkg::t_in_item                   i_in_item,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output mcbq_pkg::t_out_item                  o_out_item,
    input  logic                                 i_cfg_we,
    input  logic [mcbq_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [mcbq_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import mcbq_pkg::*;

    t_coefs                  r_coefs;
    logic [ENABLE_BITS-1:0]  r_enable;
    logic                    cfg_clear;
    logic                    q_valid;
    logic                    q_pop;
    t_q_entry                q_entry;

    // Any coefficient write drops every delay line
    always_comb begin
        cfg_clear = 1'b0;
        if (i_cfg_we) begin
            case (i_cfg_index)
                REG_COEF_B0, REG_COEF_B1, REG_COEF_B2,
                REG_COEF_A1, REG_COEF_A2: begin
                    cfg_clear = 1'b1;
                end
                default: begin
                    cfg_clear = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs    <= '{b0: COEF_B0_RESET, b1: '0, b2: '0, a1: '0, a2: '0};
            r_enable   <= ENABLE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_COEF_B0:     r_coefs.b0 <= i_cfg_data;
                REG_COEF_B1:     r_coefs.b1 <= i_cfg_data;
                REG_COEF_B2:     r_coefs.b2 <= i_cfg_data;
                REG_COEF_A1:     r_coefs.a1 <= i_cfg_data;
                REG_COEF_A2:     r_coefs.a2 <= i_cfg_data;
                REG_CHAN_ENABLE: r_enable   <= i_cfg_data[ENABLE_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    mcbq_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .i_enable   (r_enable),
        .o_q_valid  (q_valid),
        .o_q_entry  (q_entry),
        .i_q_pop    (q_pop)
    );

    mcbq_back #(
        .CHANNELS (CHANNELS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clear     (cfg_clear),
        .i_coefs     (r_coefs),
        .i_q_valid   (q_valid),
        .i_q_entry   (q_entry),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

`ifndef SYNTHESIS
    // Back end only takes from a queue that holds a request
    a_pop_needs_entry: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid
    ) else $error("queue popped while empty");

    // A full queue must be presenting a request to the back end
    a_full_has_entry: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> q_valid
    ) else $error("input stalled with nothing queued");

    // Reset leaves no result pending
    a_reset_clears_out: assert property (
        @(posedge i_clk)
        !i_rst_n |=> !o_out_valid
    ) else $error("result valid right after reset");
`endif

endmodule
